// ----- hdl/cflc_pkg.sv -----
// Shared types, constants and the CRC-32 byte update for the log record checker.
// No dependencies; imported by cflc_event_if, cflc_front, cflc_queue, cflc_back and the top level.
package cflc_pkg;

    localparam int OFFSET_BITS  = 40;
    localparam int LEN_BITS     = 21;
    localparam int HDR_BYTES    = 12;
    localparam int HDR_BITS     = HDR_BYTES * 8;

    localparam logic [31:0] CRC_POLY      = 32'hEDB88320;
    localparam logic [31:0] CRC_ONES      = 32'hFFFFFFFF;
    localparam logic [31:0] MAGIC_RESET   = 32'h4A514C31;
    localparam logic [LEN_BITS-1:0] MAX_LEN_RESET = LEN_BITS'(1 << 20);

    // Configuration register indexes
    localparam logic REG_MAGIC   = 1'b0;
    localparam logic REG_MAX_LEN = 1'b1;

    // Event codes
    localparam logic [2:0] EV_GOOD     = 3'd0;
    localparam logic [2:0] EV_END      = 3'd1;
    localparam logic [2:0] EV_BADHDR   = 3'd2;
    localparam logic [2:0] EV_SHORTHDR = 3'd3;
    localparam logic [2:0] EV_SHORTPAY = 3'd4;
    localparam logic [2:0] EV_CRC      = 3'd5;

    // Front scan phases
    localparam logic [1:0] PH_HEADER  = 2'd0;
    localparam logic [1:0] PH_PAYLOAD = 2'd1;
    localparam logic [1:0] PH_FAILED  = 2'd2;

    // Operation kinds passed from front to back
    localparam logic [1:0] OP_BYTE   = 2'd0;
    localparam logic [1:0] OP_BADHDR = 2'd1;
    localparam logic [1:0] OP_END    = 2'd2;

    typedef struct packed {
        logic [1:0]          kind;
        logic [7:0]          data;
        logic                last;
        logic [LEN_BITS-1:0] length;
        logic [31:0]         crc;
        logic                emit;
        logic [2:0]          end_code;
    } op_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef struct packed {
        logic [1:0] phase;
        logic [3:0] hdr_count;
    } f_status_t;

    // Reflected CRC-32 update over one byte
    function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ----- hdl/cflc_byte_if.sv -----
// Input byte channel of the log record checker.
// Depends on nothing.
interface cflc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       end_of_data;

    modport source (output valid, output byte_value, output end_of_data, input ready);
    modport sink   (input valid, input byte_value, input end_of_data, output ready);
endinterface

// ----- hdl/cflc_event_if.sv -----
// Event result channel of the log record checker.
// Uses OFFSET_BITS and LEN_BITS of cflc_pkg for the field widths.
interface cflc_event_if
    import cflc_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [2:0]             event_code;
    logic [OFFSET_BITS-1:0] record_offset;
    logic [LEN_BITS-1:0]    record_length;
    logic [OFFSET_BITS-1:0] good_offset;

    modport source (output valid, output event_code, output record_offset,
                    output record_length, output good_offset, input ready);
    modport sink   (input valid, input event_code, input record_offset,
                    input record_length, input good_offset, output ready);
endinterface

// ----- hdl/cflc_cfg_if.sv -----
// Configuration write channel of the log record checker.
// Depends on nothing.
interface cflc_cfg_if;
    logic        valid;
    logic        ready;
    logic        reg_index;
    logic [31:0] wr_data;

    modport source (output valid, output reg_index, output wr_data, input ready);
    modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

// ----- hdl/cflc_front.sv -----
// Front end: accepts stream bytes, parses and validates the 12-byte header,
// counts payload bytes and queues operations for the back end. Uses cflc_pkg.
module cflc_front
    import cflc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    cflc_byte_if.sink           in_ch,
    input  logic [31:0]         magic,
    input  logic [LEN_BITS-1:0] max_len,
    input  logic                q_full,
    output logic                push,
    output op_t                 op,
    output f_status_t           stat
);

    logic [1:0]          phase_reg, phase_next;
    logic [3:0]          hcnt_reg, hcnt_next;
    logic [HDR_BITS-1:0] hdr_reg, hdr_next;
    logic [LEN_BITS-1:0] len_reg, len_next;
    logic [31:0]         crc_reg, crc_next;
    logic [LEN_BITS-1:0] pcnt_reg, pcnt_next;
    logic                accept;
    logic                op_valid;
    logic [LEN_BITS-1:0] pcnt_inc;
    logic [HDR_BITS-1:0] hdr_shift;
    logic [31:0]         hdr_len;
    logic                hdr_ok;

    assign in_ch.ready = !q_full;
    assign accept      = in_ch.valid && in_ch.ready;
    assign push        = accept && op_valid;
    assign stat        = '{phase: phase_reg, hdr_count: hcnt_reg};

    // Little-endian header: shift each byte in from the top
    assign hdr_shift = {in_ch.byte_value, hdr_reg[HDR_BITS-1:8]};
    assign hdr_len   = hdr_shift[63:32];
    assign hdr_ok    = (hdr_shift[31:0] == magic) && (hdr_len != 32'd0) &&
                       (hdr_len <= {{(32-LEN_BITS){1'b0}}, max_len});
    assign pcnt_inc  = pcnt_reg + LEN_BITS'(1);

    // Classify the byte and build the operation
    always_comb
    begin
        phase_next  = phase_reg;
        hcnt_next   = hcnt_reg;
        hdr_next    = hdr_reg;
        len_next    = len_reg;
        crc_next    = crc_reg;
        pcnt_next   = pcnt_reg;
        op_valid    = 1'b0;
        op          = '0;
        op.data     = in_ch.byte_value;
        op.length   = len_reg;
        op.crc      = crc_reg;
        op.last     = (pcnt_inc == len_reg);
        if (in_ch.end_of_data)
        begin
            op_valid = 1'b1;
            op.kind  = OP_END;
            unique case (phase_reg)
                PH_HEADER:
                begin
                    op.emit     = 1'b1;
                    op.end_code = (hcnt_reg == 4'd0) ? EV_END : EV_SHORTHDR;
                end
                PH_PAYLOAD:
                begin
                    op.emit     = 1'b1;
                    op.end_code = EV_SHORTPAY;
                end
                default:
                begin
                    op.emit = 1'b0;
                end
            endcase
            phase_next = PH_HEADER;
            hcnt_next  = 4'd0;
            pcnt_next  = '0;
        end
        else
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    hdr_next  = hdr_shift;
                    hcnt_next = hcnt_reg + 4'd1;
                    if (hcnt_reg == 4'(HDR_BYTES - 1))
                    begin
                        hcnt_next = 4'd0;
                        if (hdr_ok)
                        begin
                            phase_next = PH_PAYLOAD;
                            len_next   = hdr_len[LEN_BITS-1:0];
                            crc_next   = hdr_shift[95:64];
                            pcnt_next  = '0;
                        end
                        else
                        begin
                            phase_next = PH_FAILED;
                            op_valid   = 1'b1;
                            op.kind    = OP_BADHDR;
                        end
                    end
                end
                PH_PAYLOAD:
                begin
                    op_valid  = 1'b1;
                    op.kind   = OP_BYTE;
                    pcnt_next = pcnt_inc;
                    if (op.last)
                    begin
                        phase_next = PH_HEADER;
                        hcnt_next  = 4'd0;
                    end
                end
                default:
                begin
                    op_valid = 1'b0;
                end
            endcase
        end
    end

    // Advance control state on each transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            hcnt_reg  <= 4'd0;
            pcnt_reg  <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            hcnt_reg  <= hcnt_next;
            pcnt_reg  <= pcnt_next;
        end
    end

    // Hold header fields
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hdr_reg <= hdr_next;
            len_reg <= len_next;
            crc_reg <= crc_next;
        end
    end

endmodule

// ----- hdl/cflc_queue.sv -----
// Two-entry operation queue between the front and back ends.
// Uses op_t and q_status_t from cflc_pkg.
module cflc_queue
    import cflc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  op_t       push_op,
    input  logic      pop,
    output op_t       head,
    output q_status_t stat
);

    op_t        mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg, count_next;

    assign stat.full  = (count_reg == 2'd2);
    assign stat.empty = (count_reg == 2'd0);
    assign head       = mem[rd_ptr_reg];

    // Track fill level
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_op;
        end
    end

endmodule

// ----- hdl/cflc_back.sv -----
// Back end: runs CRC-32 over payload bytes, tracks the last good offset and
// registers one event per reportable operation. Uses cflc_pkg.
module cflc_back
    import cflc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  q_status_t    q_stat,
    input  op_t          head,
    output logic         pop,
    cflc_event_if.source out_ch
);

    logic                   failed_reg, failed_next;
    logic [31:0]            crc_reg, crc_next;
    logic [OFFSET_BITS-1:0] lgo_reg, lgo_next;
    logic                   ovalid_reg;
    logic [2:0]             code_reg;
    logic [OFFSET_BITS-1:0] roff_reg, goff_reg;
    logic [LEN_BITS-1:0]    rlen_reg;
    logic                   can_load;
    logic                   emit;
    logic [2:0]             ev_code;
    logic [LEN_BITS-1:0]    ev_len;
    logic [OFFSET_BITS-1:0] ev_goff;
    logic [31:0]            crc_calc;

    assign can_load = !ovalid_reg || out_ch.ready;
    assign pop      = !q_stat.empty && can_load;
    assign crc_calc = crc_byte(crc_reg, head.data);

    // Carry out the operation at the queue head
    always_comb
    begin
        failed_next = failed_reg;
        crc_next    = crc_reg;
        lgo_next    = lgo_reg;
        emit        = 1'b0;
        ev_code     = EV_GOOD;
        ev_len      = '0;
        ev_goff     = lgo_reg;
        unique case (head.kind)
            OP_BYTE:
            begin
                if (!failed_reg)
                begin
                    crc_next = crc_calc;
                    if (head.last)
                    begin
                        crc_next = CRC_ONES;
                        emit     = 1'b1;
                        if ((crc_calc ^ CRC_ONES) != head.crc)
                        begin
                            ev_code     = EV_CRC;
                            failed_next = 1'b1;
                        end
                        else
                        begin
                            ev_code  = EV_GOOD;
                            ev_len   = head.length;
                            ev_goff  = lgo_reg + OFFSET_BITS'(HDR_BYTES) +
                                       {{(OFFSET_BITS-LEN_BITS){1'b0}}, head.length};
                            lgo_next = ev_goff;
                        end
                    end
                end
            end
            OP_BADHDR:
            begin
                if (!failed_reg)
                begin
                    emit        = 1'b1;
                    ev_code     = EV_BADHDR;
                    failed_next = 1'b1;
                end
            end
            OP_END:
            begin
                emit        = !failed_reg && head.emit;
                ev_code     = head.end_code;
                failed_next = 1'b0;
                crc_next    = CRC_ONES;
                lgo_next    = '0;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    // Advance scan state on each pop
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            failed_reg <= 1'b0;
            crc_reg    <= CRC_ONES;
            lgo_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                failed_reg <= failed_next;
                crc_reg    <= crc_next;
                lgo_reg    <= lgo_next;
            end
            if (pop && emit)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    // Load the output register
    always_ff @(posedge clk)
    begin
        if (pop && emit)
        begin
            code_reg <= ev_code;
            roff_reg <= lgo_reg;
            rlen_reg <= ev_len;
            goff_reg <= ev_goff;
        end
    end

    assign out_ch.valid         = ovalid_reg;
    assign out_ch.event_code    = code_reg;
    assign out_ch.record_offset = roff_reg;
    assign out_ch.record_length = rlen_reg;
    assign out_ch.good_offset   = goff_reg;

endmodule

// ----- hdl/crc_framed_log_record_checker.sv -----
// Top level of the length-prefixed log record checker with CRC-32 check.
// Uses cflc_pkg, the three channel interfaces, cflc_front, cflc_queue, cflc_back.

// The checker takes one stream byte per clock cycle, sustained, as long as the
// event channel keeps up. Bytes enter a header parser, which hands payload bytes,
// header faults and end-of-data marks through a two-entry queue to a CRC unit that
// folds one byte per cycle; an event is loaded into the output register when the
// queue entry of the byte or end-of-data item that caused it is popped, which
// waits until that register is free. The output register holds a finished event
// while new bytes keep flowing, until the queue fills. Configuration writes are
// always accepted and should be made while no stream is in flight.
module crc_framed_log_record_checker
    import cflc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    cflc_byte_if.sink    in_ch,
    cflc_event_if.source out_ch,
    cflc_cfg_if.sink     cfg_ch
);

    logic [31:0]         magic_reg;
    logic [LEN_BITS-1:0] max_len_reg;
    logic                push;
    logic                pop;
    op_t                 push_op;
    op_t                 head;
    q_status_t           q_stat;
    f_status_t           f_stat;

    // Configuration registers
    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_reg   <= MAGIC_RESET;
            max_len_reg <= MAX_LEN_RESET;
        end
        else if (cfg_ch.valid && cfg_ch.ready)
        begin
            unique case (cfg_ch.reg_index)
                REG_MAGIC:   magic_reg   <= cfg_ch.wr_data;
                REG_MAX_LEN: max_len_reg <= cfg_ch.wr_data[LEN_BITS-1:0];
                default:     magic_reg   <= magic_reg;
            endcase
        end
    end

    cflc_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .magic   (magic_reg),
        .max_len (max_len_reg),
        .q_full  (q_stat.full),
        .push    (push),
        .op      (push_op),
        .stat    (f_stat)
    );

    cflc_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .pop     (pop),
        .head    (head),
        .stat    (q_stat)
    );

    cflc_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_stat (q_stat),
        .head   (head),
        .pop    (pop),
        .out_ch (out_ch)
    );

`ifndef SYNTHESIS
    // End-of-data rearms the header parser
    a_end_rearms: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready && in_ch.end_of_data) |=>
        (f_stat.phase == PH_HEADER && f_stat.hdr_count == 4'd0))
        else $error("header parser not rearmed after end-of-data");

    // A good record advances the good offset by header plus payload
    a_good_offset: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.event_code == EV_GOOD) |->
        (out_ch.good_offset == out_ch.record_offset + OFFSET_BITS'(HDR_BYTES) +
         {{(OFFSET_BITS-LEN_BITS){1'b0}}, out_ch.record_length}))
        else $error("good offset does not follow record length");

    // Other events carry no length and leave the good offset
    a_fault_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.event_code != EV_GOOD) |->
        (out_ch.record_length == '0 && out_ch.good_offset == out_ch.record_offset))
        else $error("non-good event with length or moved offset");

    // Queue never reports full and empty together
    a_queue_sane: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("queue status inconsistent");
`endif

endmodule
